// ===== hdl/dgts_pkg.sv =====
`timescale 1ns / 1ps
// shared types, constants and helpers of the distance grid trilinear sampler
package dgts_pkg;

    localparam int MAX_GRID    = 64;
    localparam int N_MIN       = 2;
    localparam int GRID_W      = 7;
    localparam int CRD_W       = $clog2(MAX_GRID);
    localparam int STORE_DEPTH = MAX_GRID * MAX_GRID * MAX_GRID;
    localparam int ADDR_W      = 18;
    localparam int VALUE_W     = 18;
    localparam int PT_W        = 20;
    localparam int OUT_W       = 26;
    localparam int FRAC_W      = 16;
    localparam int S_W         = PT_W + GRID_W + 1;
    localparam int IDX_W       = S_W - FRAC_W;
    localparam int W_W         = FRAC_W + 2;
    localparam int PEN_W       = S_W + 2;
    localparam int BL_W        = 24;
    localparam int PROD_W      = BL_W + 1 + W_W;
    localparam int ZN_W        = CRD_W + GRID_W;
    localparam int NN_W        = 2 * GRID_W;
    localparam int STEP_W      = 4;
    localparam int EPS_Q16     = 66;
    localparam int OUT_MAX     = (1 << OUT_W) - 1;

    localparam logic [GRID_W-1:0]  GRID_RESET = GRID_W'(64);
    localparam logic [VALUE_W-1:0] VALUE_MAX  = '1;

    localparam logic KIND_WRITE = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    typedef struct packed {
        logic                    kind;
        logic [ADDR_W-1:0]       cell_address;
        logic [VALUE_W-1:0]      cell_value;
        logic signed [PT_W-1:0]  point_x;
        logic signed [PT_W-1:0]  point_y;
        logic signed [PT_W-1:0]  point_z;
    } request_t;

    typedef struct packed {
        logic [OUT_W-1:0] sampled_distance;
        logic             outside;
    } result_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCALE,
        ST_INDEX,
        ST_ADDR0,
        ST_ADDR1,
        ST_BLEND,
        ST_PENALTY
    } ctrl_state_t;

    typedef enum logic [1:0] {
        LS_EDGE,
        LS_FACE0,
        LS_FACE1,
        LS_BODY
    } lerp_src_t;

    typedef enum logic [2:0] {
        LD_E00,
        LD_E10,
        LD_E01,
        LD_E11,
        LD_F0,
        LD_F1,
        LD_FINAL
    } lerp_dst_t;

    typedef struct packed {
        logic       clear_we;
        logic       store_write;
        logic       load;
        logic       scale;
        logic       index;
        logic       addr0;
        logic       addr1;
        logic       rd_en;
        logic [2:0] rd_corner;
        logic       lerp_go;
        lerp_src_t  lerp_src;
        lerp_dst_t  lerp_dst;
        logic       emit_blend;
        logic       emit_penalty;
    } dp_cmd_t;

    typedef struct packed {
        logic clear_done;
        logic outside;
    } dp_status_t;

    function automatic logic [OUT_W-1:0] sat_out(input logic signed [PEN_W-1:0] v);
        logic [OUT_W-1:0] r;
        if (v < 0)
        begin
            r = '0;
        end
        else if (v > $signed(PEN_W'(OUT_MAX)))
        begin
            r = OUT_W'(OUT_MAX);
        end
        else
        begin
            r = v[OUT_W-1:0];
        end
        return r;
    endfunction

endpackage

// ===== hdl/dgts_ram.sv =====
`timescale 1ns / 1ps
// generic single write port, single read port ram with registered read
module dgts_ram #(
    parameter int DATA_W = 18,
    parameter int DEPTH  = 1024,
    localparam int AW    = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              we,
    input  logic [AW-1:0]     waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic              re,
    input  logic [AW-1:0]     raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hdl/dgts_ctrl.sv =====
`timescale 1ns / 1ps
// controller state machine: clear pass, query sequencing and blend schedule
module dgts_ctrl
    import dgts_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  logic       kind,
    input  dp_status_t status,
    output logic       busy,
    output dp_cmd_t    cmd
);

    localparam logic [STEP_W-1:0] LAST_READ  = STEP_W'(7);
    localparam logic [STEP_W-1:0] STEP_E00   = STEP_W'(2);
    localparam logic [STEP_W-1:0] STEP_E10   = STEP_W'(4);
    localparam logic [STEP_W-1:0] STEP_E01   = STEP_W'(6);
    localparam logic [STEP_W-1:0] STEP_F0    = STEP_W'(7);
    localparam logic [STEP_W-1:0] STEP_E11   = STEP_W'(8);
    localparam logic [STEP_W-1:0] STEP_F1    = STEP_W'(10);
    localparam logic [STEP_W-1:0] STEP_BODY  = STEP_W'(12);
    localparam logic [STEP_W-1:0] STEP_EMIT  = STEP_W'(14);

    ctrl_state_t       state_reg, state_next;
    logic [STEP_W-1:0] step_reg, step_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        cmd        = '0;
        busy       = 1'b1;
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear_we = 1'b1;
                if (status.clear_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                busy = 1'b0;
                if (start)
                begin
                    if (kind == KIND_QUERY)
                    begin
                        cmd.load   = 1'b1;
                        state_next = ST_SCALE;
                    end
                    else
                    begin
                        cmd.store_write = 1'b1;
                    end
                end
            end
            ST_SCALE:
            begin
                cmd.scale  = 1'b1;
                state_next = ST_INDEX;
            end
            ST_INDEX:
            begin
                cmd.index  = 1'b1;
                state_next = ST_ADDR0;
            end
            ST_ADDR0:
            begin
                cmd.addr0 = 1'b1;
                if (status.outside)
                begin
                    state_next = ST_PENALTY;
                end
                else
                begin
                    state_next = ST_ADDR1;
                end
            end
            ST_ADDR1:
            begin
                cmd.addr1  = 1'b1;
                step_next  = '0;
                state_next = ST_BLEND;
            end
            ST_BLEND:
            begin
                step_next = step_reg + STEP_W'(1);
                if (step_reg <= LAST_READ)
                begin
                    cmd.rd_en     = 1'b1;
                    cmd.rd_corner = step_reg[2:0];
                end
                case (step_reg)
                    STEP_E00:
                    begin
                        cmd.lerp_go  = 1'b1;
                        cmd.lerp_src = LS_EDGE;
                        cmd.lerp_dst = LD_E00;
                    end
                    STEP_E10:
                    begin
                        cmd.lerp_go  = 1'b1;
                        cmd.lerp_src = LS_EDGE;
                        cmd.lerp_dst = LD_E10;
                    end
                    STEP_E01:
                    begin
                        cmd.lerp_go  = 1'b1;
                        cmd.lerp_src = LS_EDGE;
                        cmd.lerp_dst = LD_E01;
                    end
                    STEP_F0:
                    begin
                        cmd.lerp_go  = 1'b1;
                        cmd.lerp_src = LS_FACE0;
                        cmd.lerp_dst = LD_F0;
                    end
                    STEP_E11:
                    begin
                        cmd.lerp_go  = 1'b1;
                        cmd.lerp_src = LS_EDGE;
                        cmd.lerp_dst = LD_E11;
                    end
                    STEP_F1:
                    begin
                        cmd.lerp_go  = 1'b1;
                        cmd.lerp_src = LS_FACE1;
                        cmd.lerp_dst = LD_F1;
                    end
                    STEP_BODY:
                    begin
                        cmd.lerp_go  = 1'b1;
                        cmd.lerp_src = LS_BODY;
                        cmd.lerp_dst = LD_FINAL;
                    end
                    STEP_EMIT:
                    begin
                        cmd.emit_blend = 1'b1;
                        step_next      = '0;
                        state_next     = ST_IDLE;
                    end
                    default:
                    begin
                    end
                endcase
            end
            ST_PENALTY:
            begin
                cmd.emit_penalty = 1'b1;
                state_next       = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== hdl/dgts_datapath.sv =====
`timescale 1ns / 1ps
// datapath: grid store, scaling, cell index, corner fetch, blend unit and penalty
module dgts_datapath
    import dgts_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  dp_cmd_t           cmd,
    output dp_status_t        status,
    input  request_t          request,
    input  logic              cfg_valid,
    input  logic [GRID_W-1:0] cfg_data,
    output logic              result_valid,
    output result_t           result
);

    localparam logic signed [S_W-1:0]    FRAC_MASK  = S_W'((1 << FRAC_W) - 1);
    localparam logic signed [PROD_W-1:0] ROUND_HALF = PROD_W'(1 << (FRAC_W - 1));

    // configuration and control
    logic [GRID_W-1:0] grid_size_reg;
    logic [ADDR_W-1:0] clr_reg;
    logic              l_valid_reg;
    logic              result_valid_reg;

    // payload
    request_t                  req_reg;
    logic [GRID_W-1:0]         n_reg;
    logic signed [S_W-1:0]     s_reg   [3];
    logic signed [IDX_W-1:0]   idx_reg [3];
    logic signed [W_W-1:0]     w_reg   [3];
    logic signed [PEN_W-1:0]   pen_reg [3];
    logic                      outside_reg;
    logic [ZN_W-1:0]           zn_reg;
    logic [NN_W-1:0]           nn_reg;
    logic [ADDR_W-1:0]         base_reg;
    logic [VALUE_W-1:0]        prev_reg;
    logic signed [BL_W-1:0]    l_a_reg;
    logic signed [PROD_W-1:0]  l_prod_reg;
    lerp_dst_t                 l_dst_reg;
    logic signed [BL_W-1:0]    e00_reg, e10_reg, e01_reg, e11_reg;
    logic signed [BL_W-1:0]    f0_reg, f1_reg, final_reg;
    result_t                   result_reg;

    logic [GRID_W-1:0]         n_clamped;
    logic [GRID_W-1:0]         n_m1;
    logic signed [IDX_W-1:0]   idx_next [3];
    logic signed [W_W-1:0]     w_next   [3];
    logic signed [PEN_W-1:0]   pen_next [3];
    logic                      outside_next;
    logic                      in_store;
    logic                      ram_we;
    logic [ADDR_W-1:0]         ram_waddr;
    logic [VALUE_W-1:0]        ram_wdata;
    logic [ADDR_W-1:0]         rd_addr;
    logic [VALUE_W-1:0]        rd_data;
    logic signed [BL_W-1:0]    la, lb;
    logic signed [W_W-1:0]     lw;
    logic signed [BL_W:0]      ldiff;
    logic signed [PROD_W-1:0]  prod_next;
    logic signed [PROD_W-1:0]  rnd;
    logic signed [BL_W-1:0]    lres;
    logic signed [PEN_W-1:0]   pen_sum;

    always_comb
    begin
        if (grid_size_reg < GRID_W'(N_MIN))
        begin
            n_clamped = GRID_W'(N_MIN);
        end
        else if (grid_size_reg > GRID_W'(MAX_GRID))
        begin
            n_clamped = GRID_W'(MAX_GRID);
        end
        else
        begin
            n_clamped = grid_size_reg;
        end
    end

    assign n_m1 = n_reg - GRID_W'(1);

    // cell index truncated toward zero, weight and per axis penalty
    always_comb
    begin
        logic signed [S_W-1:0] s;
        logic signed [S_W-1:0] q;
        logic signed [S_W-1:0] wfull;
        logic signed [S_W-1:0] top;
        logic                  below;
        logic                  above;
        outside_next = 1'b0;
        top = $signed(S_W'(n_m1) << FRAC_W);
        for (int k = 0; k < 3; k++)
        begin
            s           = s_reg[k];
            q           = (s[S_W-1] ? s + FRAC_MASK : s) >>> FRAC_W;
            wfull       = s - (q <<< FRAC_W);
            idx_next[k] = q[IDX_W-1:0];
            w_next[k]   = wfull[W_W-1:0];
            below       = q[S_W-1];
            above       = (s >= top);
            if (below)
            begin
                pen_next[k] = -PEN_W'(s);
            end
            else if (above)
            begin
                pen_next[k] = PEN_W'(s) - PEN_W'(top) + PEN_W'(EPS_Q16);
            end
            else
            begin
                pen_next[k] = '0;
            end
            outside_next = outside_next | below | above;
        end
    end

    // grid store write side: clear pass or write word
    assign in_store = ({1'b0, request.cell_address} < (ADDR_W + 1)'(STORE_DEPTH));

    always_comb
    begin
        if (cmd.clear_we)
        begin
            ram_we    = 1'b1;
            ram_waddr = clr_reg;
            ram_wdata = VALUE_MAX;
        end
        else
        begin
            ram_we    = cmd.store_write & in_store;
            ram_waddr = request.cell_address;
            ram_wdata = request.cell_value;
        end
    end

    assign rd_addr = base_reg
                   + (cmd.rd_corner[0] ? ADDR_W'(1) : '0)
                   + (cmd.rd_corner[1] ? ADDR_W'(n_reg) : '0)
                   + (cmd.rd_corner[2] ? ADDR_W'(nn_reg) : '0);

    dgts_ram #(
        .DATA_W (VALUE_W),
        .DEPTH  (STORE_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (cmd.rd_en),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    // blend unit operand select
    always_comb
    begin
        case (cmd.lerp_src)
            LS_EDGE:
            begin
                la = $signed({{(BL_W - VALUE_W){1'b0}}, prev_reg});
                lb = $signed({{(BL_W - VALUE_W){1'b0}}, rd_data});
                lw = w_reg[0];
            end
            LS_FACE0:
            begin
                la = e00_reg;
                lb = e10_reg;
                lw = w_reg[1];
            end
            LS_FACE1:
            begin
                la = e01_reg;
                lb = e11_reg;
                lw = w_reg[1];
            end
            default:
            begin
                la = f0_reg;
                lb = f1_reg;
                lw = w_reg[2];
            end
        endcase
        ldiff     = (BL_W + 1)'(lb) - (BL_W + 1)'(la);
        prod_next = ldiff * lw;
    end

    assign rnd     = (l_prod_reg + ROUND_HALF) >>> FRAC_W;
    assign lres    = l_a_reg + $signed(rnd[BL_W-1:0]);
    assign pen_sum = pen_reg[0] + pen_reg[1] + pen_reg[2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_size_reg    <= GRID_RESET;
            clr_reg          <= '0;
            l_valid_reg      <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                grid_size_reg <= cfg_data;
            end
            if (cmd.clear_we)
            begin
                clr_reg <= clr_reg + ADDR_W'(1);
            end
            l_valid_reg      <= cmd.lerp_go;
            result_valid_reg <= cmd.emit_blend | cmd.emit_penalty;
        end
    end

    always_ff @(posedge clk)
    begin
        prev_reg <= rd_data;
        if (cmd.load)
        begin
            req_reg <= request;
            n_reg   <= n_clamped;
        end
        if (cmd.scale)
        begin
            s_reg[0] <= req_reg.point_x * $signed({1'b0, n_reg});
            s_reg[1] <= req_reg.point_y * $signed({1'b0, n_reg});
            s_reg[2] <= req_reg.point_z * $signed({1'b0, n_reg});
        end
        if (cmd.index)
        begin
            for (int k = 0; k < 3; k++)
            begin
                idx_reg[k] <= idx_next[k];
                w_reg[k]   <= w_next[k];
                pen_reg[k] <= pen_next[k];
            end
            outside_reg <= outside_next;
        end
        if (cmd.addr0)
        begin
            zn_reg <= ZN_W'(idx_reg[2][CRD_W-1:0]) * ZN_W'(n_reg)
                    + ZN_W'(idx_reg[1][CRD_W-1:0]);
            nn_reg <= NN_W'(n_reg) * NN_W'(n_reg);
        end
        if (cmd.addr1)
        begin
            base_reg <= ADDR_W'(zn_reg) * ADDR_W'(n_reg) + ADDR_W'(idx_reg[0][CRD_W-1:0]);
        end
        if (cmd.lerp_go)
        begin
            l_a_reg    <= la;
            l_prod_reg <= prod_next;
            l_dst_reg  <= cmd.lerp_dst;
        end
        if (l_valid_reg)
        begin
            case (l_dst_reg)
                LD_E00:   e00_reg   <= lres;
                LD_E10:   e10_reg   <= lres;
                LD_E01:   e01_reg   <= lres;
                LD_E11:   e11_reg   <= lres;
                LD_F0:    f0_reg    <= lres;
                LD_F1:    f1_reg    <= lres;
                LD_FINAL: final_reg <= lres;
                default:
                begin
                end
            endcase
        end
        if (cmd.emit_blend)
        begin
            result_reg.sampled_distance <= sat_out(PEN_W'(final_reg));
            result_reg.outside          <= 1'b0;
        end
        else if (cmd.emit_penalty)
        begin
            result_reg.sampled_distance <= sat_out(pen_sum);
            result_reg.outside          <= 1'b1;
        end
    end

    assign status.clear_done = (clr_reg == ADDR_W'(STORE_DEPTH - 1));
    assign status.outside    = outside_reg;
    assign result_valid      = result_valid_reg;
    assign result            = result_reg;

endmodule

// ===== hdl/distance_grid_trilinear_sample_core.sv =====
`timescale 1ns / 1ps
// distance grid trilinear sampler, top level
// write word: busy stays low, the next word is taken in the following cycle
// query inside the grid: busy stays high until the result strobe, so one query is taken at a time;
//   the result follows eight corner reads through the single read port of the grid ram and the blend unit
// query outside the grid: no corner reads, the penalty result follows the address check, one query at a time
// after reset busy stays high while the grid is cleared to its maximum value;
//   grid_size returns to 64 and configuration writes are taken at any time
module distance_grid_trilinear_sample_core
    import dgts_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  request_t          request,
    output logic              result_valid,
    output result_t           result,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [GRID_W-1:0] cfg_data
);

    dp_cmd_t    cmd;
    dp_status_t status;

    dgts_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .kind   (request.kind),
        .status (status),
        .busy   (busy),
        .cmd    (cmd)
    );

    dgts_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .request      (request),
        .cfg_valid    (cfg_valid),
        .cfg_data     (cfg_data),
        .result_valid (result_valid),
        .result       (result)
    );

    assign cfg_ready = 1'b1;

endmodule

// ===== tb/dgts_checker.sv =====
`timescale 1ns / 1ps
// checker for the distance grid sampler: tracks grid and size, predicts samples, compares results
module dgts_checker
    import dgts_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic              busy,
    input  request_t          request,
    input  logic              result_valid,
    input  result_t           result,
    input  logic              cfg_valid,
    input  logic              cfg_ready,
    input  logic [GRID_W-1:0] cfg_data,
    output int                errors,
    output int                pending,
    output int                writes_seen,
    output int                blends_seen,
    output int                penalties_seen
);

    localparam longint ONE_Q16  = 65536;
    localparam longint HALF_Q16 = 32768;

    logic [VALUE_W-1:0] grid_values [STORE_DEPTH];
    logic [GRID_W-1:0]  grid_size;
    result_t            expected_samples [$];

    task automatic report(string msg);
        $display("%0t ns: %s", $time, msg);
        errors++;
    endtask

    function automatic longint corner_value(longint n, longint x, longint y, longint z);
        return longint'(grid_values[(z * n + y) * n + x]);
    endfunction

    function automatic longint blend_q16(longint a, longint b, longint w);
        return (a * (ONE_Q16 - w) + b * w + HALF_Q16) >>> FRAC_W;
    endfunction

    function automatic result_t predict_sample(request_t q);
        longint n;
        longint total;
        longint s [3];
        longint cidx [3];
        longint w [3];
        longint e00, e10, e01, e11, f0, f1;
        logic signed [PT_W-1:0] p [3];
        result_t r;
        n = longint'(grid_size);
        if (n < N_MIN)
        begin
            n = N_MIN;
        end
        if (n > MAX_GRID)
        begin
            n = MAX_GRID;
        end
        p[0] = q.point_x;
        p[1] = q.point_y;
        p[2] = q.point_z;
        r.outside = 1'b0;
        for (int k = 0; k < 3; k++)
        begin
            s[k]    = longint'(p[k]) * n;
            cidx[k] = s[k] / ONE_Q16;
            w[k]    = s[k] - cidx[k] * ONE_Q16;
            if (cidx[k] < 0 || cidx[k] >= n - 1)
            begin
                r.outside = 1'b1;
            end
        end
        if (r.outside)
        begin
            total = 0;
            for (int k = 0; k < 3; k++)
            begin
                if (cidx[k] < 0)
                begin
                    total += -s[k];
                end
                else if (cidx[k] >= n - 1)
                begin
                    total += s[k] - (n - 1) * ONE_Q16 + EPS_Q16;
                end
            end
        end
        else
        begin
            e00 = blend_q16(corner_value(n, cidx[0], cidx[1], cidx[2]),
                            corner_value(n, cidx[0] + 1, cidx[1], cidx[2]), w[0]);
            e10 = blend_q16(corner_value(n, cidx[0], cidx[1] + 1, cidx[2]),
                            corner_value(n, cidx[0] + 1, cidx[1] + 1, cidx[2]), w[0]);
            e01 = blend_q16(corner_value(n, cidx[0], cidx[1], cidx[2] + 1),
                            corner_value(n, cidx[0] + 1, cidx[1], cidx[2] + 1), w[0]);
            e11 = blend_q16(corner_value(n, cidx[0], cidx[1] + 1, cidx[2] + 1),
                            corner_value(n, cidx[0] + 1, cidx[1] + 1, cidx[2] + 1), w[0]);
            f0 = blend_q16(e00, e10, w[1]);
            f1 = blend_q16(e01, e11, w[1]);
            total = blend_q16(f0, f1, w[2]);
        end
        if (total < 0)
        begin
            total = 0;
        end
        if (total > OUT_MAX)
        begin
            total = OUT_MAX;
        end
        r.sampled_distance = total[OUT_W-1:0];
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        result_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < STORE_DEPTH; i++)
            begin
                grid_values[i] = VALUE_MAX;
            end
            grid_size = GRID_RESET;
            expected_samples.delete();
            errors         = 0;
            pending        = 0;
            writes_seen    = 0;
            blends_seen    = 0;
            penalties_seen = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                grid_size = cfg_data;
            end
            if (result_valid)
            begin
                if (expected_samples.size() == 0)
                begin
                    report($sformatf("result with nothing expected: distance %0d outside %0b",
                                     result.sampled_distance, result.outside));
                end
                else
                begin
                    want = expected_samples.pop_front();
                    if (result.sampled_distance !== want.sampled_distance)
                    begin
                        report($sformatf("sampled_distance got %0d expected %0d",
                                         result.sampled_distance, want.sampled_distance));
                    end
                    if (result.outside !== want.outside)
                    begin
                        report($sformatf("outside got %0b expected %0b",
                                         result.outside, want.outside));
                    end
                    if (want.outside)
                    begin
                        penalties_seen++;
                    end
                    else
                    begin
                        blends_seen++;
                    end
                end
            end
            if (start && !busy)
            begin
                if (request.kind == KIND_WRITE)
                begin
                    grid_values[request.cell_address] = request.cell_value;
                    writes_seen++;
                end
                else
                begin
                    expected_samples.insert(expected_samples.size(), predict_sample(request));
                end
            end
            pending = expected_samples.size();
        end
    end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// testbench top for the distance grid sampler: reset, stimulus, grid size phases and verdict
module tb_top;
    import dgts_pkg::*;

    localparam int CYCLE_LIMIT  = 1500000;
    localparam int DRAIN_CYCLES = 30;
    localparam int PHASE_ITEMS  = 100;

    logic              clk = 1'b0;
    logic              rst_n;
    logic              start;
    logic              busy;
    request_t          request;
    logic              result_valid;
    result_t           result;
    logic              cfg_valid;
    logic              cfg_ready;
    logic [GRID_W-1:0] cfg_data;

    int   errors;
    int   pending;
    int   writes_seen;
    int   blends_seen;
    int   penalties_seen;
    int   cycles = 0;
    int   items_sent = 0;
    int   sizes_run = 1;
    int   grid_n = 64;
    logic burst = 1'b0;

    distance_grid_trilinear_sample_core dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .request      (request),
        .result_valid (result_valid),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data)
    );

    dgts_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .request        (request),
        .result_valid   (result_valid),
        .result         (result),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data),
        .errors         (errors),
        .pending        (pending),
        .writes_seen    (writes_seen),
        .blends_seen    (blends_seen),
        .penalties_seen (penalties_seen)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("cycle limit reached with %0d samples outstanding", pending);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // called at a falling edge, returns at the falling edge after the word is taken
    task automatic send_word(request_t w);
        int gap;
        gap = burst ? 0 : $urandom_range(0, 11);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        start   <= 1'b1;
        request <= w;
        do
        begin
            @(posedge clk);
        end
        while (busy);
        @(negedge clk);
        items_sent++;
    endtask

    task automatic write_cell(int addr, int value);
        request_t w;
        w.kind         = KIND_WRITE;
        w.cell_address = ADDR_W'(addr);
        w.cell_value   = VALUE_W'(value);
        w.point_x      = PT_W'($urandom);
        w.point_y      = PT_W'($urandom);
        w.point_z      = PT_W'($urandom);
        send_word(w);
    endtask

    task automatic query(int px, int py, int pz);
        request_t w;
        w.kind         = KIND_QUERY;
        w.cell_address = ADDR_W'($urandom);
        w.cell_value   = VALUE_W'($urandom);
        w.point_x      = PT_W'(px);
        w.point_y      = PT_W'(py);
        w.point_z      = PT_W'(pz);
        send_word(w);
    endtask

    task automatic wait_idle();
        start <= 1'b0;
        while (pending != 0)
        begin
            @(negedge clk);
        end
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic set_grid(int value);
        wait_idle();
        cfg_valid <= 1'b1;
        cfg_data  <= GRID_W'(value);
        do
        begin
            @(posedge clk);
        end
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
        grid_n = (value < N_MIN) ? N_MIN : (value > MAX_GRID) ? MAX_GRID : value;
        sizes_run++;
    endtask

    function automatic int cell_addr(int x, int y, int z);
        return (z * grid_n + y) * grid_n + x;
    endfunction

    function automatic int pick_value();
        int r;
        r = $urandom_range(0, 7);
        if (r == 0)
        begin
            return 0;
        end
        if (r == 1)
        begin
            return VALUE_MAX;
        end
        return $urandom_range(0, VALUE_MAX);
    endfunction

    // coordinate whose scaled value lands in cell c, or just below it when the random offset is small
    function automatic int cell_point(int c);
        return (c * 65536 + $urandom_range(0, 65535)) / grid_n;
    endfunction

    // coordinate near a grid border, near the first inner cell boundary, or random
    function automatic int boundary_coord();
        case ($urandom_range(0, 4))
            0: return -$urandom_range(1, 65535 / grid_n);
            1: return (grid_n - 1) * 65536 / grid_n - $urandom_range(0, 1);
            2: return -(65536 / grid_n) + $urandom_range(0, 1) - 1;
            3: return 65535 / grid_n * grid_n / grid_n + $urandom_range(0, 2);
            default: return $urandom_range(0, 65535);
        endcase
    endfunction

    task automatic random_phase(int count);
        int first;
        int cx, cy, cz;
        first = items_sent;
        while (items_sent - first < count)
        begin
            burst = ($urandom_range(0, 3) == 0);
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5:
                begin
                    cx = $urandom_range(0, grid_n - 2);
                    cy = $urandom_range(0, grid_n - 2);
                    cz = $urandom_range(0, grid_n - 2);
                    for (int k = 0; k < 8; k++)
                    begin
                        write_cell(cell_addr(cx + k[0], cy + k[1], cz + k[2]), pick_value());
                    end
                    repeat ($urandom_range(1, 3))
                    begin
                        query(cell_point(cx), cell_point(cy), cell_point(cz));
                    end
                end
                6:
                begin
                    repeat ($urandom_range(1, 4))
                    begin
                        write_cell($urandom_range(0, STORE_DEPTH - 1), $urandom_range(0, VALUE_MAX));
                    end
                end
                7:
                begin
                    query($urandom, $urandom, $urandom);
                end
                8:
                begin
                    query(boundary_coord(), boundary_coord(), boundary_coord());
                end
                default:
                begin
                    query($urandom_range(0, 69535) - 2000, $urandom_range(0, 69535) - 2000,
                          $urandom_range(0, 69535) - 2000);
                end
            endcase
        end
    endtask

    initial
    begin
        int sizes [10];
        sizes = '{2, 3, 0, 127, 1, 64, 5, 17, 100, 0};
        sizes[9] = $urandom_range(2, 64);
        rst_n     = 1'b0;
        start     = 1'b0;
        request   = '0;
        cfg_valid = 1'b0;
        cfg_data  = GRID_RESET;
        repeat (6) @(negedge clk);
        rst_n = 1'b1;

        // directed words at the reset grid size
        write_cell(0, 0);
        write_cell(STORE_DEPTH - 1, 0);
        write_cell(1, VALUE_MAX);
        query(0, 0, 0);
        query(-1, 0, 0);
        query(-1, -1, -1);
        query(524287, 524287, 524287);
        query(-524288, -524288, -524288);
        query(-524288, 0, 524287);
        query(64512, 0, 0);
        query(64511, 64511, 64511);
        query(-1024, 0, 0);
        query(-1023, 0, 0);
        write_cell(64, 12345);
        write_cell(4096, VALUE_MAX);
        write_cell(65, 0);
        query(512, 512, 512);
        query(1023, 1023, 1023);

        random_phase(PHASE_ITEMS);
        foreach (sizes[i])
        begin
            set_grid(sizes[i]);
            random_phase(PHASE_ITEMS);
        end

        wait_idle();
        $display("%0d words sent over %0d grid size settings: %0d writes, %0d blended samples,",
                 items_sent, sizes_run, writes_seen, blends_seen);
        $display("%0d outside penalties, %0d mismatches", penalties_seen, errors);
        if (errors == 0)
        begin
            $display("Testbench completed without errors");
        end
        else
        begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
